// ----- hw/rtl/ntb16_pkg.sv -----
package ntb16_pkg;
   localparam int BufBytesDefault = 4096;
   localparam int MaxDescDefault  = 63;
   localparam int NthLen = 12;
   localparam int NdpMin = 16;

   localparam logic [2:0] ST_DONE     = 3'd0;
   localparam logic [2:0] ST_BAD_HDR  = 3'd1;
   localparam logic [2:0] ST_BAD_TBL  = 3'd2;
   localparam logic [2:0] ST_BACKWARD = 3'd3;
   localparam logic [2:0] ST_TBL_LIM  = 3'd4;
   localparam logic [2:0] ST_DESC_CAP = 3'd5;

   localparam logic [1:0] CSR_MIN_LEN = 2'd0;
   localparam logic [1:0] CSR_MAX_NDP = 2'd1;
   localparam logic [1:0] CSR_CRC_NDP = 2'd2;

   typedef struct packed {
      logic        is_end;
      logic [15:0] dg_offset;
      logic [15:0] dg_length;
      logic [5:0]  dg_count;
      logic [2:0]  end_status;
      logic        truncated;
   } rsp_type;
endpackage

// ----- hw/rtl/ntb16_if.sv -----
interface ntb16_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source (output valid, data_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface ntb16_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_end;
   logic [15:0] dg_offset;
   logic [15:0] dg_length;
   logic [5:0]  dg_count;
   logic [2:0]  end_status;
   logic        truncated;
   modport source (output valid, is_end, dg_offset, dg_length, dg_count, end_status,
                   truncated, input ready);
   modport sink   (input valid, is_end, dg_offset, dg_length, dg_count, end_status,
                   truncated, output ready);
endinterface

// ----- hw/rtl/ntb16_receive_parser.sv -----
// Loading: one byte per cycle, req ready while the block is being received.
// After the last byte the walker reads the buffer through a single read port,
// one byte at a time through the states S_RD, S_RD_WAIT and S_RD_TAKE: 12 bytes
// for the header, 8 per table header and 4 per table entry. Each result waits in
// the output register until taken.
// Synchronous active-high reset clears the control state and restores CSR defaults;
// the byte buffer is not cleared (only bytes of the current block are read).
module ntb16_receive_parser
   import ntb16_pkg::*;
#(
   parameter int BUF_BYTES       = BufBytesDefault,
   parameter int MAX_DESCRIPTORS = MaxDescDefault
) (
   input  logic         clock,
   input  logic         reset,
   ntb16_req_if.sink    req,
   ntb16_rsp_if.source  rsp,
   input  logic         csr_write,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_data
);
   localparam int AW = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
   localparam int CW = $clog2(BUF_BYTES + 1);
   localparam logic [CW-1:0] BufFull = CW'(BUF_BYTES);
   localparam logic [5:0] DescCap = 6'(MAX_DESCRIPTORS);

   typedef enum logic [3:0] {
      S_LOAD, S_RD, S_RD_WAIT, S_RD_TAKE, S_HDR, S_TBL_CHK, S_TBL_SIG,
      S_TBL_HDR, S_ENT, S_ENT_CHK, S_NEXT, S_END, S_OUT
   } state_type;

   // which value the byte reader is fetching
   typedef enum logic [2:0] {
      F_HDR, F_TBL, F_ENT
   } fetch_type;

   logic [7:0] mem [BUF_BYTES];
   logic [7:0] rdata_ff;

   state_type   state_ff;
   fetch_type   fetch_ff;
   logic [CW-1:0] count_ff;
   logic        dropped_ff;
   logic [15:0] min_len_ff;
   logic [6:0]  max_ndp_ff;
   logic        crc_ok_ff;
   logic [16:0] addr_ff;      // byte address being fetched
   logic [3:0]  nleft_ff;     // bytes still to fetch
   logic [3:0]  bidx_ff;
   logic [7:0]  buf_ff [12];  // fetched bytes
   logic [16:0] limit_ff;
   logic [16:0] ndp_ff;
   logic [16:0] tail_ff;
   logic [16:0] next_ff;
   logic [16:0] ent_ff;
   logic [6:0]  visits_ff;
   logic [5:0]  emitted_ff;
   logic [2:0]  status_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic [7:0] rbyte;
   logic [15:0] w0, w1;
   assign w0 = {buf_ff[1], buf_ff[0]};
   assign w1 = {buf_ff[3], buf_ff[2]};
   // out-of-range and unwritten bytes read as zero
   assign rbyte = (addr_ff < 17'(count_ff)) ? rdata_ff : 8'd0;

   assign req.ready = (state_ff == S_LOAD);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.is_end = rsp_ff.is_end;
   assign rsp.dg_offset = rsp_ff.dg_offset;
   assign rsp.dg_length = rsp_ff.dg_length;
   assign rsp.dg_count = rsp_ff.dg_count;
   assign rsp.end_status = rsp_ff.end_status;
   assign rsp.truncated = rsp_ff.truncated;

   // buffer write and registered read
   always_ff @(posedge clock) begin
      if (req.valid && req.ready && count_ff < BufFull)
         mem[count_ff[AW-1:0]] <= req.data_byte;
      rdata_ff <= mem[addr_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD; fetch_ff <= F_HDR;
         count_ff <= '0; dropped_ff <= 1'b0;
         min_len_ff <= 16'd14; max_ndp_ff <= 7'd16; crc_ok_ff <= 1'b1;
         visits_ff <= '0; emitted_ff <= '0; status_ff <= ST_DONE;
         rsp_valid_ff <= 1'b0;
         addr_ff <= '0; nleft_ff <= '0; bidx_ff <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_MIN_LEN: min_len_ff <= csr_data;
               CSR_MAX_NDP: max_ndp_ff <= csr_data[6:0];
               CSR_CRC_NDP: crc_ok_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_LOAD: if (req.valid) begin
               if (count_ff < BufFull) count_ff <= count_ff + 1'b1;
               else dropped_ff <= 1'b1;
               if (req.last_byte) begin
                  if ((count_ff < BufFull ? count_ff + 1'b1 : count_ff) < CW'(NthLen))
                  begin
                     status_ff <= ST_BAD_HDR; state_ff <= S_END;
                  end else begin
                     addr_ff <= '0; nleft_ff <= 4'd12; bidx_ff <= '0;
                     fetch_ff <= F_HDR; state_ff <= S_RD;
                  end
               end
            end
            // byte reader: address set, then S_RD_WAIT waits for the registered data
            S_RD: state_ff <= S_RD_WAIT;
            S_RD_WAIT: state_ff <= S_RD_TAKE;
            S_RD_TAKE: begin
               buf_ff[bidx_ff] <= rbyte;
               bidx_ff <= bidx_ff + 1'b1;
               addr_ff <= addr_ff + 1'b1;
               if (nleft_ff == 4'd1) begin
                  unique case (fetch_ff)
                     F_HDR: state_ff <= S_HDR;
                     F_TBL: state_ff <= S_TBL_SIG;
                     default: state_ff <= S_ENT_CHK;
                  endcase
               end else state_ff <= S_RD;
               nleft_ff <= nleft_ff - 1'b1;
            end
            S_HDR: begin
               if (buf_ff[0] != "N" || buf_ff[1] != "C" || buf_ff[2] != "M" ||
                   buf_ff[3] != "H") begin
                  status_ff <= ST_BAD_HDR; state_ff <= S_END;
               end else begin
                  limit_ff <= ({buf_ff[9], buf_ff[8]} == 16'd0 ||
                               17'({buf_ff[9], buf_ff[8]}) > 17'(count_ff)) ?
                              17'(count_ff) : 17'({buf_ff[9], buf_ff[8]});
                  ndp_ff <= 17'({buf_ff[11], buf_ff[10]});
                  if ({buf_ff[11], buf_ff[10]} == 16'd0) begin
                     status_ff <= ST_BAD_TBL; state_ff <= S_END;
                  end else state_ff <= S_TBL_CHK;
               end
            end
            S_TBL_CHK: begin
               if (visits_ff >= max_ndp_ff) begin
                  status_ff <= ST_TBL_LIM; state_ff <= S_END;
               end else begin
                  visits_ff <= visits_ff + 1'b1;
                  if (ndp_ff + 17'd8 > limit_ff) begin
                     status_ff <= ST_BAD_TBL; state_ff <= S_END;
                  end else begin
                     addr_ff <= ndp_ff; nleft_ff <= 4'd8; bidx_ff <= '0;
                     fetch_ff <= F_TBL; state_ff <= S_RD;
                  end
               end
            end
            S_TBL_SIG: begin
               if (buf_ff[0] != "N" || buf_ff[1] != "C" || buf_ff[2] != "M" ||
                   !(buf_ff[3] == "0" || (buf_ff[3] == "1" && crc_ok_ff))) begin
                  status_ff <= ST_BAD_TBL; state_ff <= S_END;
               end else begin
                  tail_ff <= ndp_ff + 17'({buf_ff[5], buf_ff[4]});
                  next_ff <= 17'({buf_ff[7], buf_ff[6]});
                  state_ff <= S_TBL_HDR;
               end
            end
            S_TBL_HDR: begin
               if ({buf_ff[5], buf_ff[4]} < 16'(NdpMin) || tail_ff > limit_ff) begin
                  status_ff <= ST_BAD_TBL; state_ff <= S_END;
               end else begin
                  ent_ff <= ndp_ff + 17'd8; state_ff <= S_ENT;
               end
            end
            S_ENT: begin
               if (ent_ff + 17'd4 > tail_ff) state_ff <= S_NEXT;
               else begin
                  addr_ff <= ent_ff; nleft_ff <= 4'd4; bidx_ff <= '0;
                  fetch_ff <= F_ENT; state_ff <= S_RD;
               end
            end
            S_ENT_CHK: if (!rsp_valid_ff) begin
               if (w0 == 16'd0 && w1 == 16'd0) state_ff <= S_NEXT;
               else if (w1 >= min_len_ff && 17'(w0) + 17'(w1) <= limit_ff) begin
                  if (emitted_ff >= DescCap) begin
                     status_ff <= ST_DESC_CAP; state_ff <= S_END;
                  end else begin
                     rsp_ff <= '{1'b0, w0, w1, 6'd0, ST_DONE, 1'b0};
                     rsp_valid_ff <= 1'b1;
                     emitted_ff <= emitted_ff + 1'b1;
                     ent_ff <= ent_ff + 17'd4; state_ff <= S_ENT;
                  end
               end else begin
                  ent_ff <= ent_ff + 17'd4; state_ff <= S_ENT;
               end
            end
            S_NEXT: begin
               if (next_ff == 17'd0) begin
                  status_ff <= ST_DONE; state_ff <= S_END;
               end else if (next_ff <= ndp_ff) begin
                  status_ff <= ST_BACKWARD; state_ff <= S_END;
               end else begin
                  ndp_ff <= next_ff; state_ff <= S_TBL_CHK;
               end
            end
            S_END: if (!rsp_valid_ff) begin
               rsp_ff <= '{1'b1, 16'd0, 16'd0, emitted_ff, status_ff, dropped_ff};
               rsp_valid_ff <= 1'b1;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               count_ff <= '0; dropped_ff <= 1'b0;
               visits_ff <= '0; emitted_ff <= '0;
               state_ff <= S_LOAD;
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end
endmodule

// ----- tb/sv/ntb16_checker.sv -----
module ntb16_checker
   import ntb16_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ntb16_req_if        req,
   ntb16_rsp_if        rsp,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          pending,
   output int          rsp_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // shadow of the block buffer and its per-block state
   logic [7:0]  stash [BufBytesDefault];
   int unsigned rx_count;
   bit          overflowed;

   // shadow configuration
   logic [15:0] min_len;
   logic [6:0]  max_ndp;
   logic        crc_ok;

   rsp_type     expected_q [$];

   assign pending = expected_q.size();

   function automatic int unsigned rd8(int unsigned i);
      if (i >= BufBytesDefault || i >= rx_count) return 0;
      return stash[i];
   endfunction

   function automatic int unsigned rd16(int unsigned i);
      return rd8(i) | (rd8(i + 1) << 8);
   endfunction

   function automatic bit ncm_tag(int unsigned i);
      return rd8(i) == "N" && rd8(i + 1) == "C" && rd8(i + 2) == "M";
   endfunction

   // check the header, walk the table chain, queue descriptors, return the end status
   function automatic logic [2:0] walk_chain(output int unsigned emitted);
      int unsigned lim, decl, ptr, tlen, nxt, tail, ep, di, dl, visits, sig;
      rsp_type     d;
      emitted = 0;
      visits  = 0;
      if (rx_count < NthLen || !ncm_tag(0) || rd8(3) != "H") return ST_BAD_HDR;
      decl = rd16(8);
      lim  = (decl == 0 || decl > rx_count) ? rx_count : decl;
      ptr  = rd16(10);
      if (ptr == 0) return ST_BAD_TBL;
      forever begin
         if (visits >= max_ndp) return ST_TBL_LIM;
         visits++;
         if (ptr + 8 > lim || !ncm_tag(ptr)) return ST_BAD_TBL;
         sig = rd8(ptr + 3);
         if (!(sig == "0" || (sig == "1" && crc_ok))) return ST_BAD_TBL;
         tlen = rd16(ptr + 4);
         nxt  = rd16(ptr + 6);
         tail = ptr + tlen;
         if (tlen < NdpMin || tail > lim) return ST_BAD_TBL;
         for (ep = ptr + 8; ep + 4 <= tail; ep += 4) begin
            di = rd16(ep);
            dl = rd16(ep + 2);
            if (di == 0 && dl == 0) break;
            if (dl >= min_len && di + dl <= lim) begin
               if (emitted >= MaxDescDefault) return ST_DESC_CAP;
               d = '0;
               d.dg_offset = di[15:0];
               d.dg_length = dl[15:0];
               expected_q.push_back(d);
               emitted++;
            end
         end
         if (nxt == 0) return ST_DONE;
         if (nxt <= ptr) return ST_BACKWARD;
         ptr = nxt;
      end
   endfunction

   // store one byte; the last one of a block runs the parse
   task automatic absorb_byte();
      int unsigned n;
      rsp_type     e;
      if (rx_count < BufBytesDefault) begin
         stash[rx_count] = req.data_byte;
         rx_count++;
      end else begin
         overflowed = 1'b1;
      end
      if (req.last_byte) begin
         e = '0;
         e.end_status = walk_chain(n);
         e.is_end     = 1'b1;
         e.dg_count   = n[5:0];
         e.truncated  = overflowed;
         expected_q.push_back(e);
         rx_count   = 0;
         overflowed = 1'b0;
      end
   endtask

   function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   task automatic check_result();
      rsp_type e;
      rsp_count++;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected result, actual end=%0d off=%0d len=%0d", $time,
                  rsp.is_end, rsp.dg_offset, rsp.dg_length);
         fail_count++;
         return;
      end
      e = expected_q.pop_front();
      check_field("is_end", e.is_end, rsp.is_end);
      check_field("dg_offset", e.dg_offset, rsp.dg_offset);
      check_field("dg_length", e.dg_length, rsp.dg_length);
      check_field("dg_count", e.dg_count, rsp.dg_count);
      check_field("end_status", e.end_status, rsp.end_status);
      check_field("truncated", e.truncated, rsp.truncated);
   endtask

   initial begin
      fail_count = 0;
      rsp_count  = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         min_len    = 16'd14;
         max_ndp    = 7'd16;
         crc_ok     = 1'b1;
         rx_count   = 0;
         overflowed = 1'b0;
         expected_q.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_MIN_LEN: min_len = csr_data;
               CSR_MAX_NDP: max_ndp = csr_data[6:0];
               CSR_CRC_NDP: crc_ok  = csr_data[0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) absorb_byte();
         if (rsp.valid && rsp.ready) check_result();
      end
   end
endmodule

// ----- tb/sv/testbench.sv -----
module testbench
   import ntb16_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // block shapes
   localparam int SHAPE_CLEAN   = 0;
   localparam int SHAPE_FLIP    = 1;
   localparam int SHAPE_BACK    = 2;
   localparam int SHAPE_ZEROPTR = 3;
   localparam int SHAPE_NCM1    = 4;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = CSR_MIN_LEN;
   logic [15:0] csr_data = '0;
   bit          idle_on = 1'b1;
   int          fail_count, pending, rsp_count;
   int          bytes_sent = 0;
   int          blocks_sent = 0;
   logic [7:0]  blk [$];

   ntb16_req_if req_if ();
   ntb16_rsp_if rsp_if ();

   ntb16_receive_parser i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   ntb16_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .rsp        (rsp_if),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending),
      .rsp_count  (rsp_count)
   );

   always #1 clock = ~clock;

   // result side backpressure
   always @(posedge clock) begin
      rsp_if.ready <= !(idle_on && $urandom_range(0, 99) < 12);
   end

   task automatic put16(int unsigned at, int unsigned v);
      blk[at]     = v[7:0];
      blk[at + 1] = v[15:8];
   endtask

   // build a transfer block with a table chain and random payload; links run forward but for the last one in SHAPE_BACK
   task automatic make_chain(int ntab, int shape);
      int unsigned ne [4];
      int unsigned tpos [4];
      int unsigned pos, dpos, total, t, k, dlen, ep, nxt;
      pos = 12;
      for (t = 0; t < ntab; t++) begin
         ne[t]   = $urandom_range(0, 4);
         tpos[t] = pos;
         pos    += 8 + 4 * (ne[t] + 1);
      end
      dpos  = pos;
      total = pos;
      for (t = 0; t < ntab; t++) total += ne[t] * 30;
      total += 4;
      blk.delete();
      for (k = 0; k < total; k++) blk.push_back($urandom_range(0, 255));
      blk[0] = "N"; blk[1] = "C"; blk[2] = "M"; blk[3] = "H";
      put16(4, 12);
      for (t = 0; t < ntab; t++) begin
         blk[tpos[t]] = "N"; blk[tpos[t] + 1] = "C"; blk[tpos[t] + 2] = "M";
         blk[tpos[t] + 3] = (shape == SHAPE_NCM1 || $urandom_range(0, 99) < 20) ? "1" : "0";
         put16(tpos[t] + 4, 8 + 4 * (ne[t] + 1));
         nxt = (t + 1 < ntab) ? tpos[t + 1] : 0;
         if (shape == SHAPE_BACK && t + 1 == ntab) nxt = tpos[$urandom_range(0, t)];
         put16(tpos[t] + 6, nxt);
         ep = tpos[t] + 8;
         for (k = 0; k < ne[t]; k++) begin
            dlen = $urandom_range(0, 29);
            // now and then an entry that runs off the end
            if ($urandom_range(0, 99) < 8) put16(ep, total - 3); else put16(ep, dpos);
            put16(ep + 2, dlen);
            dpos += dlen;
            ep   += 4;
         end
         put16(ep, 0);
         put16(ep + 2, $urandom_range(0, 99) < 85 ? 0 : 1);
      end
      case ($urandom_range(0, 9))
         0:       put16(8, 0);
         1:       put16(8, total + $urandom_range(1, 300));
         2:       put16(8, total - $urandom_range(0, 20));
         default: put16(8, total);
      endcase
      put16(10, shape == SHAPE_ZEROPTR ? 0 : tpos[0]);
      if (shape == SHAPE_FLIP) blk[$urandom_range(0, pos - 1)] ^= 8'd1 << $urandom_range(0, 7);
   endtask

   // random bytes, sometimes opening with a valid signature
   task automatic make_noise(int unsigned len);
      int unsigned k;
      blk.delete();
      for (k = 0; k < len; k++) blk.push_back($urandom_range(0, 255));
      if (len >= 4 && $urandom_range(0, 1)) begin
         blk[0] = "N"; blk[1] = "C"; blk[2] = "M"; blk[3] = "H";
      end
   endtask

   // one table holding more acceptable entries than the descriptor cap
   task automatic make_cap_block();
      int unsigned k, total;
      total = 12 + 8 + 4 * 71 + 8;
      blk.delete();
      for (k = 0; k < total; k++) blk.push_back($urandom_range(0, 255));
      blk[0] = "N"; blk[1] = "C"; blk[2] = "M"; blk[3] = "H";
      put16(8, total);
      put16(10, 12);
      blk[12] = "N"; blk[13] = "C"; blk[14] = "M"; blk[15] = "0";
      put16(16, 8 + 4 * 71);
      put16(18, 0);
      for (k = 0; k < 70; k++) begin
         put16(20 + 4 * k, total - 8 + (k % 4));
         put16(22 + 4 * k, k % 3);
      end
      put16(20 + 4 * 70, 0);
      put16(22 + 4 * 70, 0);
   endtask

   // send the block, one transaction per byte
   task automatic send_block();
      int unsigned i;
      bit          hit;
      for (i = 0; i < blk.size(); i++) begin
         if (idle_on && $urandom_range(0, 99) < 12) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
         req_if.valid     <= 1'b1;
         req_if.data_byte <= blk[i];
         req_if.last_byte <= (i + 1 == blk.size());
         do begin
            @(negedge clock);
            hit = req_if.ready;
            @(posedge clock);
         end while (!hit);
         bytes_sent++;
      end
      blocks_sent++;
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_config(int unsigned min_len, int unsigned max_ndp, int unsigned crc);
      csr_write <= 1'b1;
      csr_index <= CSR_MIN_LEN;
      csr_data  <= 16'(min_len);
      @(posedge clock);
      csr_index <= CSR_MAX_NDP;
      csr_data  <= 16'(max_ndp);
      @(posedge clock);
      csr_index <= CSR_CRC_NDP;
      csr_data  <= 16'(crc);
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // run guard
   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int k;
      req_if.valid     = 1'b0;
      req_if.data_byte = '0;
      req_if.last_byte = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_config(14, 16, 1);

      // directed: header and table corner cases at default settings
      make_noise(5);                   send_block();
      make_noise(12);                  send_block();
      make_chain(1, SHAPE_ZEROPTR);    send_block();
      make_chain(1, SHAPE_CLEAN);      send_block();
      make_chain(2, SHAPE_NCM1);       send_block();
      make_chain(3, SHAPE_BACK);       send_block();
      make_chain(2, SHAPE_FLIP);       send_block();
      drain();

      // zero length floor, table limit of 64, no idling at all
      idle_on = 1'b0;
      set_config(0, 64, 1);
      make_cap_block();                send_block();
      make_chain(4, SHAPE_CLEAN);      send_block();
      drain();
      idle_on = 1'b1;

      // longest length floor, single table, checksum tables refused
      set_config(65535, 1, 0);
      make_chain(3, SHAPE_CLEAN);      send_block();
      make_chain(1, SHAPE_NCM1);       send_block();
      drain();

      // buffer overflow
      set_config(14, 16, 1);
      make_chain(2, SHAPE_CLEAN);
      while (blk.size() < BufBytesDefault + 5) blk.push_back($urandom_range(0, 255));
      send_block();
      drain();

      // random phases
      while (bytes_sent < 4096 + 700 + 310) begin
         set_config($urandom_range(0, 99) < 80 ? $urandom_range(0, 30) : $urandom_range(0, 65535),
                    $urandom_range(1, 64), $urandom_range(0, 1));
         for (k = 0; k < 6; k++) begin
            case ($urandom_range(0, 19))
               0, 1, 2: make_chain($urandom_range(1, 4), SHAPE_FLIP);
               3:       make_chain($urandom_range(1, 4), SHAPE_BACK);
               4:       make_chain($urandom_range(1, 2), SHAPE_ZEROPTR);
               5, 6:    make_noise($urandom_range(1, 40));
               default: make_chain($urandom_range(1, 4), SHAPE_CLEAN);
            endcase
            send_block();
         end
         drain();
      end

      repeat (50) @(posedge clock);
      $display("Sent %0d bytes in %0d transfer blocks, checked %0d results", bytes_sent,
               blocks_sent, rsp_count);
      $display("Covered bad headers and tables, backward links, table limit, cap, overflow");
      if (fail_count == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

// ----- filelist.f -----
hw/rtl/ntb16_pkg.sv
hw/rtl/ntb16_if.sv
hw/rtl/ntb16_receive_parser.sv
tb/sv/ntb16_checker.sv
tb/sv/testbench.sv
